@@ hw/rtl/sorted_deadline_timer_queue_macros.svh @@
// assertion macros for the sorted deadline timer queue
// expects clk and rst_n in the scope where a macro is used
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SDTQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sdtq_pkg.sv @@
// shared types and constants of the sorted deadline timer queue
// no dependencies
package sdtq_pkg;

    localparam int TAG_W = 8;
    localparam int DUR_W = 16;
    localparam int KIND_W = 2;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic ACTION_ADD = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [DUR_W-1:0] period;
        logic [TAG_W-1:0] tag;
    } entry_info_t;

    // command from the sequencer to every cell of the chain
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctl_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  fired_tag;
        logic              status;
        logic [DUR_W-1:0]  next_due_in;
        logic              is_last;
    } res_pay_t;

endpackage

@@ hw/rtl/sdtq_cmd_if.sv @@
// input channel of the timer queue: add or tick items
// depends on sdtq_pkg
interface sdtq_cmd_if;
    import sdtq_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [TAG_W-1:0]    task_tag;
    logic [DUR_W-1:0]    delay;
    logic [DUR_W-1:0]    period;

    modport source (output valid, action, task_tag, delay, period, input ready);
    modport sink (input valid, action, task_tag, delay, period, output ready);
endinterface

@@ hw/rtl/sdtq_res_if.sv @@
// result channel of the timer queue
// depends on sdtq_pkg
interface sdtq_res_if;
    import sdtq_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    fired_tag;
    logic                status;
    logic [DUR_W-1:0]    next_due_in;
    logic                is_last;

    modport source (output valid, kind, fired_tag, status, next_due_in, is_last, input ready);
    modport sink (input valid, kind, fired_tag, status, next_due_in, is_last, output ready);
endinterface

@@ hw/rtl/sdtq_cell.sv @@
// one slot of the sorted chain: holds a timer, shifts right on insert, left on pop
// depends on sdtq_pkg
module sdtq_cell #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sdtq_pkg::cell_ctl_t     ctl,
    input  logic [TIME_WIDTH-1:0]   new_dl,
    input  sdtq_pkg::entry_info_t   new_info,
    input  logic [TIME_WIDTH-1:0]   prev_dl,
    input  sdtq_pkg::entry_info_t   prev_info,
    input  logic                    prev_occ,
    input  logic                    prev_go,
    input  logic [TIME_WIDTH-1:0]   next_dl,
    input  sdtq_pkg::entry_info_t   next_info,
    input  logic                    next_occ,
    output logic [TIME_WIDTH-1:0]   dl,
    output sdtq_pkg::entry_info_t   info,
    output logic                    occ,
    output logic                    go
);
    import sdtq_pkg::*;

    logic [TIME_WIDTH-1:0] dl_reg;
    logic [TIME_WIDTH-1:0] dl_next;
    entry_info_t           info_reg;
    entry_info_t           info_next;
    logic                  occ_reg;
    logic                  occ_next;
    logic [TIME_WIDTH-1:0] diff;

    // new timer goes at or in front of this slot when the slot is empty or the new one is strictly earlier
    assign diff = new_dl - dl_reg;
    assign go = !occ_reg || diff[TIME_WIDTH-1];

    always_comb
    begin
        dl_next = dl_reg;
        info_next = info_reg;
        occ_next = occ_reg;
        priority if (ctl.ins && go && !prev_go)
        begin
            dl_next = new_dl;
            info_next = new_info;
            occ_next = 1'b1;
        end
        else if (ctl.ins && go)
        begin
            dl_next = prev_dl;
            info_next = prev_info;
            occ_next = prev_occ;
        end
        else if (ctl.pop)
        begin
            dl_next = next_dl;
            info_next = next_info;
            occ_next = next_occ;
        end
        else
        begin
            dl_next = dl_reg;
            info_next = info_reg;
            occ_next = occ_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg <= dl_next;
        info_reg <= info_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign dl = dl_reg;
    assign info = info_reg;
    assign occ = occ_reg;
endmodule

@@ hw/rtl/sorted_deadline_timer_queue.sv @@
// top level of the sorted deadline timer queue: sequencer, time base, result register
// depends on sdtq_pkg, sdtq_cmd_if, sdtq_res_if, sdtq_cell and the macros header
//
//  channel | dir | carries
//  --------+-----+---------------------------------------------------
//  cmd     | in  | action, task_tag, delay, period
//  res     | out | kind, fired_tag, status, next_due_in, is_last
//
// an add goes through the insert and output states; a tick makes one shift pass of the
// cell chain per pop of a timer fired and per re-insert of a periodic one, with at most
// MAX_RESULTS timers fired per tick.
// reset clears the occupancy of every cell at once; no clearing pass.
// results wait in a single output register; while it is held the sequencer waits.
module sorted_deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    sdtq_cmd_if.sink   cmd,
    sdtq_res_if.source res
);
    import sdtq_pkg::*;

    `include "sorted_deadline_timer_queue_macros.svh"

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ADD_INS = 3'd1;
    localparam logic [2:0] ST_ADD_OUT = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_REINS   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]      pend_tag_reg, pend_tag_next;
    logic [TIME_WIDTH-1:0] new_dl_reg, new_dl_next;
    entry_info_t           new_info_reg, new_info_next;
    logic                  full_reg, full_next;
    logic                  out_valid_reg;
    res_pay_t              out_pay_reg;

    cell_ctl_t             ctl;
    logic                  emit;
    res_pay_t              emit_pay;
    logic                  out_free;

    logic [TIME_WIDTH-1:0] dl_q [QUEUE_DEPTH];
    entry_info_t           info_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occ;
    logic [QUEUE_DEPTH-1:0] go;

    // cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [TIME_WIDTH-1:0] p_dl, n_dl;
        entry_info_t           p_info, n_info;
        logic                  p_occ, p_go, n_occ;

        if (i == 0)
        begin : g_first
            assign p_dl = new_dl_reg;
            assign p_info = new_info_reg;
            assign p_occ = 1'b0;
            assign p_go = 1'b0;
        end
        else
        begin : g_mid
            assign p_dl = dl_q[i-1];
            assign p_info = info_q[i-1];
            assign p_occ = occ[i-1];
            assign p_go = go[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign n_dl = new_dl_reg;
            assign n_info = new_info_reg;
            assign n_occ = 1'b0;
        end
        else
        begin : g_inner
            assign n_dl = dl_q[i+1];
            assign n_info = info_q[i+1];
            assign n_occ = occ[i+1];
        end

        sdtq_cell #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .new_dl    (new_dl_reg),
            .new_info  (new_info_reg),
            .prev_dl   (p_dl),
            .prev_info (p_info),
            .prev_occ  (p_occ),
            .prev_go   (p_go),
            .next_dl   (n_dl),
            .next_info (n_info),
            .next_occ  (n_occ),
            .dl        (dl_q[i]),
            .info      (info_q[i]),
            .occ       (occ[i]),
            .go        (go[i])
        );
    end

    // head timing
    logic [TIME_WIDTH-1:0] head_ahead;
    logic [TIME_WIDTH-1:0] head_behind;
    logic                  head_due;
    logic [DUR_W-1:0]      next_due;

    assign head_ahead = dl_q[0] - now_reg;
    assign head_behind = now_reg - dl_q[0];
    assign head_due = occ[0] && !head_behind[TIME_WIDTH-1]
                      && (k_reg < CNT_W'(MAX_RESULTS));

    always_comb
    begin
        if (!occ[0])
        begin
            next_due = '0;
        end
        else if (head_ahead[TIME_WIDTH-1] || head_ahead == '0)
        begin
            next_due = DUR_W'(1);
        end
        else if (|head_ahead[TIME_WIDTH-1:DUR_W])
        begin
            next_due = '1;
        end
        else
        begin
            next_due = head_ahead[DUR_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        now_next = now_reg;
        k_next = k_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next = pend_tag_reg;
        new_dl_next = new_dl_reg;
        new_info_next = new_info_reg;
        full_next = full_reg;
        ctl = '0;
        emit = 1'b0;
        emit_pay = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.action == ACTION_ADD)
                    begin
                        new_dl_next = now_reg + TIME_WIDTH'(cmd.delay);
                        new_info_next.period = cmd.period;
                        new_info_next.tag = cmd.task_tag;
                        full_next = occ[QUEUE_DEPTH-1];
                        state_next = ST_ADD_INS;
                    end
                    else
                    begin
                        now_next = now_reg + TIME_WIDTH'(1);
                        k_next = '0;
                        pend_valid_next = 1'b0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_ADD_INS:
            begin
                ctl.ins = !full_reg;
                state_next = ST_ADD_OUT;
            end
            ST_ADD_OUT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_pay.kind = KIND_ADD;
                    emit_pay.fired_tag = new_info_reg.tag;
                    emit_pay.status = full_reg ? STATUS_FULL : STATUS_OK;
                    emit_pay.next_due_in = next_due;
                    emit_pay.is_last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (head_due)
                begin
                    // the previous fired item is sent once another one follows
                    if (out_free || !pend_valid_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit = 1'b1;
                            emit_pay.kind = KIND_FIRED;
                            emit_pay.fired_tag = pend_tag_reg;
                            emit_pay.status = STATUS_OK;
                        end
                        pend_valid_next = 1'b1;
                        pend_tag_next = info_q[0].tag;
                        ctl.pop = 1'b1;
                        k_next = k_reg + CNT_W'(1);
                        new_dl_next = now_reg + TIME_WIDTH'(info_q[0].period);
                        new_info_next = info_q[0];
                        state_next = (info_q[0].period != '0) ? ST_REINS : ST_CHECK;
                    end
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    emit_pay.kind = pend_valid_reg ? KIND_FIRED : KIND_NONE;
                    emit_pay.fired_tag = pend_valid_reg ? pend_tag_reg : '0;
                    emit_pay.status = STATUS_OK;
                    emit_pay.next_due_in = next_due;
                    emit_pay.is_last = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_REINS:
            begin
                ctl.ins = 1'b1;
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            now_reg <= '0;
            k_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg <= now_next;
            k_reg <= k_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_tag_reg <= pend_tag_next;
        new_dl_reg <= new_dl_next;
        new_info_reg <= new_info_next;
        full_reg <= full_next;
        if (emit)
        begin
            out_pay_reg <= emit_pay;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.kind = out_pay_reg.kind;
    assign res.fired_tag = out_pay_reg.fired_tag;
    assign res.status = out_pay_reg.status;
    assign res.next_due_in = out_pay_reg.next_due_in;
    assign res.is_last = out_pay_reg.is_last;

    // occupied slots stay packed from the head
    `SDTQ_ASSERT_SAME(a_packed, 1'b1, ((occ >> 1) & ~occ) == '0, "occupied slots not packed")
    // an insert never lands on a full chain
    `SDTQ_ASSERT_SAME(a_ins_room, ctl.ins, !occ[QUEUE_DEPTH-1], "insert into full queue")
    // a pop always removes a timer and bumps the fired count
    `SDTQ_ASSERT_NEXT(a_pop_count, ctl.pop, k_reg == $past(k_reg) + CNT_W'(1), "fired count off")
endmodule

@@ tb/sorted_deadline_timer_queue_tb.sv @@
// testbench of the sorted deadline timer queue: random and directed add and tick items
// predicts every result with its own sorted timer list and checks each field in order
// depends on sdtq_pkg, sdtq_cmd_if, sdtq_res_if and the rtl of sorted_deadline_timer_queue
`timescale 1ns / 1ps

module sorted_deadline_timer_queue_tb;
    import sdtq_pkg::*;

    localparam int SLOTS = 16;
    localparam int TIME_W = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic             action;
        logic [TAG_W-1:0] tag;
        logic [DUR_W-1:0] delay;
        logic [DUR_W-1:0] period;
    } timer_cmd_t;

    logic clk;
    logic rst_n;

    sdtq_cmd_if cmd_ch ();
    sdtq_res_if res_ch ();

    sorted_deadline_timer_queue #(
        .QUEUE_DEPTH(SLOTS),
        .TIME_WIDTH(TIME_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_ch),
        .res(res_ch)
    );

    // timer list as the block should hold it, sorted by deadline
    logic [TIME_W-1:0] sorted_deadline [SLOTS];
    logic [DUR_W-1:0]  sorted_period [SLOTS];
    logic [TAG_W-1:0]  sorted_tag [SLOTS];
    int                armed_count = 0;
    logic [TIME_W-1:0] tick_time = '0;

    timer_cmd_t pending_cmds [$];
    res_pay_t   due_results [$];
    res_pay_t   got_want;
    timer_cmd_t next_cmd;

    int   bad_count = 0;
    int   cycle_count = 0;
    int   items_taken = 0;
    int   calm_after = 32'h7fffffff;
    int   gap_left = 0;
    int   stall_left = 0;
    bit   long_hold_done = 0;
    logic cmd_took = 1'b0;
    int   periodic_left = 4;
    int   far_left = 3;

    wire quiet = items_taken >= calm_after;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // wrap-aware: a strictly earlier than b
    function automatic bit earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

    task automatic file_timer(input logic [TIME_W-1:0] dl, input logic [DUR_W-1:0] per,
                              input logic [TAG_W-1:0] tag);
        int p;
        p = 0;
        while (p < armed_count && !earlier(dl, sorted_deadline[p]))
            p++;
        for (int i = armed_count; i > p; i--)
        begin
            sorted_deadline[i] = sorted_deadline[i-1];
            sorted_period[i] = sorted_period[i-1];
            sorted_tag[i] = sorted_tag[i-1];
        end
        sorted_deadline[p] = dl;
        sorted_period[p] = per;
        sorted_tag[p] = tag;
        armed_count++;
    endtask

    function automatic logic [DUR_W-1:0] head_wait();
        logic [TIME_W-1:0] d;
        if (armed_count == 0)
            return '0;
        d = sorted_deadline[0] - tick_time;
        if (d[TIME_W-1] || d == 0)
            return DUR_W'(1);
        if (d > 'hFFFF)
            return 16'hFFFF;
        return d[DUR_W-1:0];
    endfunction

    task automatic predict_timer_item(input timer_cmd_t c);
        res_pay_t          burst [$];
        res_pay_t          r;
        logic [DUR_W-1:0]  per;
        logic [TAG_W-1:0]  ftag;
        int                k;
        k = 0;
        r = '0;
        if (c.action == ACTION_ADD)
        begin
            r.kind = KIND_ADD;
            r.fired_tag = c.tag;
            if (armed_count >= SLOTS)
                r.status = STATUS_FULL;
            else
            begin
                r.status = STATUS_OK;
                file_timer(tick_time + c.delay, c.period, c.tag);
            end
            burst.push_back(r);
        end
        else
        begin
            tick_time = tick_time + 1;
            while (k < MAX_RESULTS && armed_count > 0 && !earlier(tick_time, sorted_deadline[0]))
            begin
                ftag = sorted_tag[0];
                per = sorted_period[0];
                for (int i = 0; i + 1 < armed_count; i++)
                begin
                    sorted_deadline[i] = sorted_deadline[i+1];
                    sorted_period[i] = sorted_period[i+1];
                    sorted_tag[i] = sorted_tag[i+1];
                end
                armed_count--;
                r = '0;
                r.kind = KIND_FIRED;
                r.fired_tag = ftag;
                r.status = STATUS_OK;
                burst.push_back(r);
                k++;
                if (per != 0)
                    file_timer(tick_time + per, per, ftag);
            end
            if (k == 0)
            begin
                r = '0;
                r.kind = KIND_NONE;
                burst.push_back(r);
            end
        end
        burst[burst.size()-1].next_due_in = head_wait();
        burst[burst.size()-1].is_last = 1'b1;
        foreach (burst[i])
            due_results.push_back(burst[i]);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            bad_count++;
        end
    endtask

    function automatic timer_cmd_t make_tick();
        timer_cmd_t c;
        // fields other than action are ignored on a tick, so they carry noise
        c.action = ACTION_TICK;
        c.tag = TAG_W'($urandom_range(0, 255));
        c.delay = DUR_W'($urandom_range(0, 65535));
        c.period = DUR_W'($urandom_range(0, 65535));
        return c;
    endfunction

    function automatic timer_cmd_t make_add(input int dly);
        timer_cmd_t c;
        c.action = ACTION_ADD;
        c.tag = TAG_W'($urandom_range(0, 255));
        c.delay = DUR_W'(dly);
        c.period = '0;
        // periodic timers never leave the list, so only a few are made
        if (periodic_left > 0 && $urandom_range(0, 19) == 0)
        begin
            c.period = DUR_W'($urandom_range(0, 1) ? $urandom_range(1, 9)
                                                   : $urandom_range(1, 65535));
            periodic_left--;
        end
        return c;
    endfunction

    // sampling side: prediction on each accepted item, check on each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_took <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_timer_item(timer_cmd_t'{cmd_ch.action, cmd_ch.task_tag, cmd_ch.delay,
                                                cmd_ch.period});
                items_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item with nothing expected, kind %0d tag %0d",
                           res_ch.kind, res_ch.fired_tag);
                    bad_count++;
                end
                else
                begin
                    got_want = due_results.pop_front();
                    check_field("kind", 16'(got_want.kind), 16'(res_ch.kind));
                    check_field("fired_tag", 16'(got_want.fired_tag), 16'(res_ch.fired_tag));
                    check_field("status", 16'(got_want.status), 16'(res_ch.status));
                    check_field("next_due_in", got_want.next_due_in, res_ch.next_due_in);
                    check_field("is_last", 16'(got_want.is_last), 16'(res_ch.is_last));
                end
            end
        end
    end

    // command driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && !cmd_took)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                if (!quiet && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(0, 10);
                    cmd_ch.valid <= 1'b0;
                end
                else
                begin
                    next_cmd = pending_cmds.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.action <= next_cmd.action;
                    cmd_ch.task_tag <= next_cmd.tag;
                    cmd_ch.delay <= next_cmd.delay;
                    cmd_ch.period <= next_cmd.period;
                end
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result back-pressure, with one long hold that fills the block
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && items_taken >= 150)
            begin
                long_hold_done = 1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int made;
        int n_add;
        int n_tick;
        int flood_dly;
        int dly;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACTION_ADD;
        cmd_ch.task_tag = '0;
        cmd_ch.delay = '0;
        cmd_ch.period = '0;
        res_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick on an empty list, then a zero delay add that is already due
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(timer_cmd_t'{ACTION_ADD, 8'd0, 16'd0, 16'd0});
        pending_cmds.push_back(make_tick());
        // farthest periodic timer, all ones
        pending_cmds.push_back(timer_cmd_t'{ACTION_ADD, 8'hFF, 16'hFFFF, 16'hFFFF});
        // equal deadlines fill the list, must fire in arrival order
        for (int i = 1; i <= 15; i++)
            pending_cmds.push_back(timer_cmd_t'{ACTION_ADD, 8'(i), 16'd1, 16'd0});
        pending_cmds.push_back(timer_cmd_t'{ACTION_ADD, 8'hA5, 16'd3, 16'd0});
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(timer_cmd_t'{ACTION_ADD, 8'h5A, 16'd2, 16'd3});
        repeat (3) pending_cmds.push_back(make_tick());

        // hold the sender until the list has settled
        while (pending_cmds.size() != 0 || cmd_ch.valid || due_results.size() != 0)
            @(posedge clk);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // many timers on one deadline, which can overflow the list
                    flood_dly = $urandom_range(0, 5);
                    repeat (10) pending_cmds.push_back(make_add(flood_dly));
                    repeat (flood_dly + 1) pending_cmds.push_back(make_tick());
                    made += 11 + flood_dly;
                end
                1:
                begin
                    repeat (12) pending_cmds.push_back(make_tick());
                    made += 12;
                end
                default:
                begin
                    n_add = $urandom_range(1, 5);
                    n_tick = $urandom_range(1, 8);
                    made += n_add + n_tick;
                    while (n_add + n_tick > 0)
                    begin
                        if (n_add > 0 && (n_tick == 0 || $urandom_range(0, 1)))
                        begin
                            dly = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40)
                                                            : $urandom_range(0, 12);
                            if (far_left > 0 && $urandom_range(0, 29) == 0)
                            begin
                                dly = $urandom_range(100, 65535);
                                far_left--;
                            end
                            pending_cmds.push_back(make_add(dly));
                            n_add--;
                        end
                        else
                        begin
                            pending_cmds.push_back(make_tick());
                            n_tick--;
                        end
                    end
                end
            endcase
        end
        calm_after = items_taken + pending_cmds.size() - 60;

        while (pending_cmds.size() != 0 || cmd_ch.valid || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sdtq_pkg.sv
hw/rtl/sdtq_cmd_if.sv
hw/rtl/sdtq_res_if.sv
hw/rtl/sdtq_cell.sv
hw/rtl/sorted_deadline_timer_queue.sv
tb/sorted_deadline_timer_queue_tb.sv
